### hw/rtl/c_lexical_token_classifier_defines.svh
// Assertion macros shared by the tokenizer RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef C_LEXICAL_TOKEN_CLASSIFIER_DEFINES_SVH
`define C_LEXICAL_TOKEN_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CLT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CLT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/clt_pkg.sv
// Shared types, constants and keyword tables for the tokenizer.
// No dependencies; the top level, the front end and the token queue import this package.
`default_nettype none

package clt_pkg;

  localparam int POS_BITS = 16;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam int NKW = 14;

  localparam int Q_DEPTH   = 4;
  localparam int QPTR_BITS = $clog2(Q_DEPTH);
  localparam int QCNT_BITS = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  typedef enum logic [2:0] {
    KIND_KEYWORD = 3'd0,
    KIND_INTEGER = 3'd1,
    KIND_IDENT   = 3'd2,
    KIND_UNKNOWN = 3'd3,
    KIND_OP      = 3'd4,
    KIND_SEP     = 3'd5,
    KIND_STRING  = 3'd6,
    KIND_PREPROC = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [3:0]  kw_index;
    logic [7:0]  ch;
    logic        last;
  } clt_token_t;

  typedef struct packed {
    logic [1:0] cnt;
    clt_token_t tok0;
    clt_token_t tok1;
  } clt_push_t;

  // Keyword text, first character in the top byte, zero padded.
  localparam logic [63:0] KW_TEXT [NKW] = '{
    {"if", 48'h0}, {"else", 32'h0}, {"while", 24'h0}, {"do", 48'h0},
    {"for", 40'h0}, {"int", 40'h0}, {"float", 24'h0}, {"char", 32'h0},
    {"return", 16'h0}, {"void", 32'h0}, {"long", 32'h0}, {"short", 24'h0},
    {"include", 8'h0}, {"printf", 16'h0}
  };

  localparam logic [3:0] KW_LEN [NKW] = '{
    4'd2, 4'd4, 4'd5, 4'd2, 4'd3, 4'd3, 4'd5,
    4'd4, 4'd6, 4'd4, 4'd4, 4'd5, 4'd7, 4'd6
  };

  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] i);
    return KW_TEXT[k][{~i, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/clt_channels.sv
// Valid/ready channel interfaces for source bytes and result tokens.
// No dependencies.
`default_nettype none

interface clt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_input;

  modport source (output valid, output char_in, output end_of_input, input ready);
  modport sink (input valid, input char_in, input end_of_input, output ready);
endinterface

interface clt_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [3:0]  keyword_index;
  logic [7:0]  token_char;
  logic        last_of_run;

  modport source (
    output valid, output token_kind, output token_start, output token_length,
    output keyword_index, output token_char, output last_of_run, input ready
  );
  modport sink (
    input valid, input token_kind, input token_start, input token_length,
    input keyword_index, input token_char, input last_of_run, output ready
  );
endinterface

`default_nettype wire

### hw/rtl/c_lexical_token_classifier.sv
// Top level of the streaming C tokenizer: scanner front end and token queue.
// Depends on clt_pkg, clt_channels, clt_front and clt_token_queue.
// Tokens are queued when the byte that closes them is accepted and offered from the queue.
// Throughput: one byte per cycle while the four-word queue has two free entries; one token
// leaves per cycle while the sink is ready, so bytes that close two tokens can hold input back.
// Reset: synchronous; the scanner returns to idle at position zero and the queue empties.
`default_nettype none

module c_lexical_token_classifier import clt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  clt_byte_if.sink    bytes,
  clt_token_if.source tokens
);

  clt_push_t push;
  logic      room;

  clt_front u_front (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .room  (room),
    .push  (push)
  );

  clt_token_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .tokens (tokens)
  );

endmodule

`default_nettype wire

### hw/rtl/clt_front.sv
// Scanner front end: accepts one byte per cycle while the queue has room, tracks
// the open lexeme and builds up to two tokens per byte. Depends on clt_pkg, clt_channels.
`default_nettype none

module clt_front import clt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  clt_byte_if.sink  bytes,
  input  logic      room,
  output clt_push_t push
);

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_WORD = 4'b0010,
    MODE_STR  = 4'b0100,
    MODE_PRE  = 4'b1000
  } mode_t;

  mode_t               mode, mode_next;
  logic                quote_single, quote_single_next;
  logic [POS_BITS-1:0] open_start, open_start_next;
  logic [POS_BITS-1:0] open_len, open_len_next;
  logic [POS_BITS-1:0] byte_pos, byte_pos_next;
  logic [NKW-1:0]      kw_cand, kw_cand_next;
  logic                all_digits, all_digits_next;
  logic                ident_ok, ident_ok_next;
  logic [7:0]          first_char, first_char_next;

  logic [NKW-1:0] cand_start, cand_cont;
  logic           accept, do_idle;
  logic           v_a, v_b, v_c;
  clt_token_t     t_a, t_b, t_c, slot0, slot1;
  logic [1:0]     n_tok;
  logic [7:0]     c, quote_ch;
  logic           eoi, c_ws, c_op, c_sep, c_digit, c_alpha;

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + POS_BITS'(1);
  endfunction

  function automatic logic [15:0] clamp(input logic [POS_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic clt_token_t mk_tok(input kind_t kind, input logic [POS_BITS-1:0] start,
                                        input logic [POS_BITS-1:0] len,
                                        input logic [3:0] kwi, input logic [7:0] ch);
    clt_token_t t;
    t.kind     = kind;
    t.start    = clamp(start);
    t.length   = clamp(len);
    t.kw_index = kwi;
    t.ch       = ch;
    t.last     = 1'b0;
    return t;
  endfunction

  function automatic clt_token_t word_tok(input logic [NKW-1:0] cand,
                                          input logic [POS_BITS-1:0] len,
                                          input logic [POS_BITS-1:0] start,
                                          input logic [7:0] first,
                                          input logic digits, input logic ident);
    logic       found;
    logic [3:0] idx;
    kind_t      kind;
    found = 1'b0;
    idx   = 4'd0;
    for (int k = NKW - 1; k >= 0; k--) begin
      if (cand[k] && (len == POS_BITS'(KW_LEN[k]))) begin
        found = 1'b1;
        idx   = 4'(k);
      end
    end
    if (found) begin
      kind = KIND_KEYWORD;
    end else if (digits) begin
      kind = KIND_INTEGER;
    end else if (ident) begin
      kind = KIND_IDENT;
    end else begin
      kind = KIND_UNKNOWN;
    end
    return mk_tok(kind, start, len, idx, first);
  endfunction

  assign c       = bytes.char_in;
  assign eoi     = bytes.end_of_input;
  assign c_ws    = (c == 8'd32) || (c inside {[8'd9:8'd13]});
  assign c_op    = c inside {"+", "-", "*", "/", ">", "<", "=", "!"};
  assign c_sep   = c inside {",", ";", "(", ")", "{", "}", "[", "]", CH_DQUOTE, CH_SQUOTE};
  assign c_digit = c inside {["0":"9"]};
  assign c_alpha = c inside {["a":"z"], ["A":"Z"]};

  assign bytes.ready = room;
  assign accept      = bytes.valid && room;

  always_comb begin
    for (int k = 0; k < NKW; k++) begin
      cand_start[k] = (kw_char(4'(k), 3'd0) == c);
      cand_cont[k]  = kw_cand[k] && (open_len < POS_BITS'(KW_LEN[k])) &&
                      (kw_char(4'(k), open_len[2:0]) == c);
    end
  end

  always_comb begin
    mode_next         = mode;
    quote_single_next = quote_single;
    open_start_next   = open_start;
    open_len_next     = open_len;
    kw_cand_next      = kw_cand;
    all_digits_next   = all_digits;
    ident_ok_next     = ident_ok;
    first_char_next   = first_char;
    byte_pos_next     = byte_pos;
    v_a = 1'b0;
    v_b = 1'b0;
    v_c = 1'b0;
    t_a = '0;
    t_b = '0;
    t_c = '0;
    do_idle  = 1'b0;
    quote_ch = quote_single ? CH_SQUOTE : CH_DQUOTE;

    case (mode)
      MODE_IDLE: begin
        do_idle = 1'b1;
      end
      MODE_PRE: begin
        if (c == CH_LF) begin
          v_a = 1'b1;
          t_a = mk_tok(KIND_PREPROC, open_start, open_len, 4'd0, first_char);
          mode_next = MODE_IDLE;
        end else begin
          open_len_next = sat_inc(open_len);
        end
      end
      MODE_STR: begin
        if (c == quote_ch) begin
          if (open_len != '0) begin
            v_a = 1'b1;
            t_a = mk_tok(KIND_STRING, open_start, open_len, 4'd0, first_char);
          end
          v_b = 1'b1;
          t_b = mk_tok(KIND_SEP, byte_pos, POS_BITS'(1), 4'd0, c);
          mode_next = MODE_IDLE;
        end else begin
          if (open_len == '0) begin
            first_char_next = c;
          end
          open_len_next = sat_inc(open_len);
        end
      end
      MODE_WORD: begin
        if (c_ws || c_op || c_sep) begin
          v_a = 1'b1;
          t_a = word_tok(kw_cand, open_len, open_start, first_char, all_digits, ident_ok);
          do_idle = 1'b1;
        end else begin
          kw_cand_next    = cand_cont;
          all_digits_next = all_digits && c_digit;
          ident_ok_next   = ident_ok && (c_alpha || c_digit || (c == CH_UNDER));
          open_len_next   = sat_inc(open_len);
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase

    if (do_idle) begin
      mode_next = MODE_IDLE;
      if (c_ws) begin
        mode_next = MODE_IDLE;
      end else if (c == CH_HASH) begin
        mode_next       = MODE_PRE;
        open_start_next = byte_pos;
        open_len_next   = POS_BITS'(1);
        first_char_next = c;
      end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
        v_b = 1'b1;
        t_b = mk_tok(KIND_SEP, byte_pos, POS_BITS'(1), 4'd0, c);
        mode_next         = MODE_STR;
        quote_single_next = (c == CH_SQUOTE);
        open_start_next   = sat_inc(byte_pos);
        open_len_next     = '0;
        first_char_next   = 8'd0;
      end else if (c_op) begin
        v_b = 1'b1;
        t_b = mk_tok(KIND_OP, byte_pos, POS_BITS'(1), 4'd0, c);
      end else if (c_sep) begin
        v_b = 1'b1;
        t_b = mk_tok(KIND_SEP, byte_pos, POS_BITS'(1), 4'd0, c);
      end else begin
        mode_next       = MODE_WORD;
        open_start_next = byte_pos;
        open_len_next   = POS_BITS'(1);
        kw_cand_next    = cand_start;
        all_digits_next = c_digit;
        ident_ok_next   = c_alpha || (c == CH_UNDER);
        first_char_next = c;
      end
    end

    if (eoi) begin
      if (mode_next == MODE_PRE) begin
        v_c = 1'b1;
        t_c = mk_tok(KIND_PREPROC, open_start_next, open_len_next, 4'd0, first_char_next);
      end else if ((mode_next == MODE_STR) && (open_len_next != '0)) begin
        v_c = 1'b1;
        t_c = mk_tok(KIND_STRING, open_start_next, open_len_next, 4'd0, first_char_next);
      end else if (mode_next == MODE_WORD) begin
        v_c = 1'b1;
        t_c = word_tok(kw_cand_next, open_len_next, open_start_next, first_char_next,
                       all_digits_next, ident_ok_next);
      end
      mode_next     = MODE_IDLE;
      byte_pos_next = '0;
    end else begin
      byte_pos_next = sat_inc(byte_pos);
    end
  end

  // A byte closes at most two tokens; pack them into the first slots in order.
  always_comb begin
    n_tok = {1'b0, v_a} + {1'b0, v_b} + {1'b0, v_c};
    slot0 = v_a ? t_a : (v_b ? t_b : t_c);
    slot1 = (v_a && v_b) ? t_b : t_c;
    slot0.last = (n_tok == 2'd1);
    slot1.last = (n_tok == 2'd2);
    push.cnt  = accept ? n_tok : 2'd0;
    push.tok0 = slot0;
    push.tok1 = slot1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      quote_single <= 1'b0;
      open_start   <= '0;
      open_len     <= '0;
      byte_pos     <= '0;
      kw_cand      <= '0;
      all_digits   <= 1'b0;
      ident_ok     <= 1'b0;
      first_char   <= 8'd0;
    end else if (accept) begin
      mode         <= mode_next;
      quote_single <= quote_single_next;
      open_start   <= open_start_next;
      open_len     <= open_len_next;
      byte_pos     <= byte_pos_next;
      kw_cand      <= kw_cand_next;
      all_digits   <= all_digits_next;
      ident_ok     <= ident_ok_next;
      first_char   <= first_char_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/clt_token_queue.sv
// Back end: a short token queue that takes up to two words per cycle from
// the scanner and drives the result channel. Depends on clt_pkg, clt_channels and the defines.
`default_nettype none
`include "c_lexical_token_classifier_defines.svh"

module clt_token_queue import clt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  clt_push_t   push,
  output logic        room,
  clt_token_if.source tokens
);

  clt_token_t mem [Q_DEPTH];

  logic [QCNT_BITS-1:0] count, count_next;
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr, wr_ptr_1;
  logic                 pop;
  clt_token_t           head;

  assign pop        = tokens.valid && tokens.ready;
  assign wr_ptr_1   = wr_ptr + QPTR_BITS'(1);
  assign count_next = count + QCNT_BITS'(push.cnt) - QCNT_BITS'(pop);
  assign room       = !rst && (count <= QCNT_BITS'(Q_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      count  <= count_next;
      wr_ptr <= wr_ptr + QPTR_BITS'(push.cnt);
      rd_ptr <= rd_ptr + QPTR_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.tok0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_1] <= push.tok1;
    end
  end

  assign head                 = mem[rd_ptr];
  assign tokens.valid         = (count != '0);
  assign tokens.token_kind    = head.kind;
  assign tokens.token_start   = head.start;
  assign tokens.token_length  = head.length;
  assign tokens.keyword_index = head.kw_index;
  assign tokens.token_char    = head.ch;
  assign tokens.last_of_run   = head.last;

  `CLT_ASSERT_NOW(a_count_bound, 1'b1, count <= QCNT_BITS'(Q_DEPTH), "queue count beyond depth")
  `CLT_ASSERT_NOW(a_push_has_room, push.cnt != 2'd0, room, "push without room in queue")
  `CLT_ASSERT_NOW(a_last_single, push.cnt == 2'd1, push.tok0.last, "single word not marked last")
  `CLT_ASSERT_NOW(a_last_pair, push.cnt == 2'd2, push.tok1.last && !push.tok0.last, "pair last mark wrong")

endmodule

`default_nettype wire
